@@ hdl/sdspi_pkg.sv @@
// shared types and constants for the sd card spi host sequencer
`default_nettype none
package sdspi_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned BC_W = 10;

    typedef enum logic [3:0] {
        PH_IDLE, PH_POWERUP, PH_CMD_PRE, PH_CMD_SEND, PH_CMD_RESP, PH_TAIL,
        PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_GAP, PH_WR_TOKEN, PH_WR_DATA,
        PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_RELEASE
    } t_phase;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_XCHG  = 2'd3;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CMD_REJ   = 3'd1;
    localparam logic [2:0] ST_TOKEN_TO  = 3'd2;
    localparam logic [2:0] ST_DATA_REJ  = 3'd3;
    localparam logic [2:0] ST_BUSY_TO   = 3'd4;
    localparam logic [2:0] ST_IDLE_FAIL = 3'd5;
    localparam logic [2:0] ST_UNKNOWN   = 3'd6;
    localparam logic [2:0] ST_SETUP     = 3'd7;

    localparam logic [2:0] CT_NONE = 3'd0;
    localparam logic [2:0] CT_SDV1 = 3'd1;
    localparam logic [2:0] CT_SDV2 = 3'd2;
    localparam logic [2:0] CT_SDHC = 3'd3;
    localparam logic [2:0] CT_MMC  = 3'd4;

    localparam logic [2:0] REG_RESP_WAIT  = 3'd0;
    localparam logic [2:0] REG_TOKEN_WAIT = 3'd1;
    localparam logic [2:0] REG_BUSY_WAIT  = 3'd2;
    localparam logic [2:0] REG_POWERUP    = 3'd3;
    localparam logic [2:0] REG_IDLE_RETRY = 3'd4;
    localparam logic [2:0] REG_ACMD_RETRY = 3'd5;
    localparam logic [2:0] REG_LEG_RETRY  = 3'd6;

    localparam logic [5:0] CMD0 = 6'd0;
    localparam logic [5:0] CMD1 = 6'd1;
    localparam logic [5:0] CMD8 = 6'd8;
    localparam logic [5:0] CMD16 = 6'd16;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD24 = 6'd24;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;
    localparam logic [5:0] CMD59 = 6'd59;

    typedef struct packed {
        logic [7:0]  resp_wait;
        logic [15:0] token_wait;
        logic [19:0] busy_wait;
        logic [7:0]  powerup;
        logic [7:0]  idle_retry;
        logic [11:0] acmd_retry;
        logic [11:0] leg_retry;
    } t_cfg;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic [7:0] data_out;
        logic       data_valid;
        logic       data_taken;
        logic       done_res;
        logic [2:0] status;
        logic [2:0] card_type;
    } t_result;

endpackage
`default_nettype wire

@@ hdl/sdspi_cfg_regs.sv @@
// configuration register bank
`default_nettype none
module sdspi_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [19:0]    i_cfg_data,
    output sdspi_pkg::t_cfg     o_cfg
);
    import sdspi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resp_wait  <= 8'd200;
            r_cfg.token_wait <= 16'd2000;
            r_cfg.busy_wait  <= 20'h40000;
            r_cfg.powerup    <= 8'd100;
            r_cfg.idle_retry <= 8'd20;
            r_cfg.acmd_retry <= 12'd255;
            r_cfg.leg_retry  <= 12'd4095;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RESP_WAIT:  r_cfg.resp_wait  <= i_cfg_data[7:0];
                REG_TOKEN_WAIT: r_cfg.token_wait <= i_cfg_data[15:0];
                REG_BUSY_WAIT:  r_cfg.busy_wait  <= i_cfg_data;
                REG_POWERUP:    r_cfg.powerup    <= i_cfg_data[7:0];
                REG_IDLE_RETRY: r_cfg.idle_retry <= i_cfg_data[7:0];
                REG_ACMD_RETRY: r_cfg.acmd_retry <= i_cfg_data[11:0];
                REG_LEG_RETRY:  r_cfg.leg_retry  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

@@ hdl/sdspi_core.sv @@
// sequencer state and per-byte next-state and result logic
`default_nettype none
module sdspi_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire sdspi_pkg::t_cfg i_cfg,
    input  wire logic [1:0]     i_mode,
    input  wire logic [31:0]    i_sector,
    input  wire logic [7:0]     i_rx_byte,
    input  wire logic [7:0]     i_wr_data,
    output sdspi_pkg::t_result  o_res
);
    import sdspi_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_dtype, n_dtype;
    logic [BC_W-1:0] r_bc, n_bc;
    logic [19:0] r_poll, n_poll;
    logic [11:0] r_retry, n_retry;
    logic [5:0]  r_cidx, n_cidx;
    logic [31:0] r_carg, n_carg;
    logic [1:0]  r_op, n_op;
    logic [2:0]  r_found, n_found;
    logic [1:0]  r_prelo, n_prelo;
    logic [1:0]  r_prehi, n_prehi;
    logic [31:0] r_tail, n_tail;
    logic [2:0]  r_fin, n_fin;
    logic        r_v2, n_v2;

    logic [7:0]  s_dout;
    logic        s_dval, s_done;
    logic [2:0]  s_st;
    logic [12:0] s_retry_inc;
    logic [BC_W:0] s_bc_inc;
    logic [20:0] s_poll_inc;
    logic [7:0]  s_r;
    logic        s_resp;

    assign s_retry_inc = {1'b0, r_retry} + 13'd1;
    assign s_bc_inc    = {1'b0, r_bc} + (BC_W+1)'(1);
    assign s_poll_inc  = {1'b0, r_poll} + 21'd1;

    always_comb begin
        n_phase = r_phase; n_dtype = r_dtype; n_bc = r_bc; n_poll = r_poll;
        n_retry = r_retry; n_cidx = r_cidx; n_carg = r_carg; n_op = r_op;
        n_found = r_found; n_prelo = r_prelo; n_prehi = r_prehi; n_tail = r_tail;
        n_fin = r_fin; n_v2 = r_v2;
        s_dout = 8'd0; s_dval = 1'b0; s_done = 1'b0; s_st = ST_OK;
        s_resp = 1'b0; s_r = i_rx_byte;

        // command start helper is inlined: it sets cidx/carg/pre and enters PH_CMD_PRE
        unique case (i_mode)
            MODE_INIT: begin
                n_op = OP_INIT; n_dtype = CT_NONE; n_found = CT_NONE; n_retry = '0;
                n_bc = '0; n_v2 = 1'b0; n_phase = PH_POWERUP;
                if (i_cfg.powerup == 8'd0) begin
                    n_cidx = CMD0; n_carg = '0; n_prelo = 2'd1; n_prehi = 2'd0;
                    n_poll = '0; n_phase = PH_CMD_PRE;
                end
            end
            MODE_READ, MODE_WRITE: begin
                n_op = (i_mode == MODE_READ) ? OP_READ : OP_WRITE;
                n_cidx = (i_mode == MODE_READ) ? CMD17 : CMD24;
                n_carg = (r_dtype == CT_SDHC) ? i_sector : {i_sector[22:0], 9'd0};
                n_prelo = 2'd1; n_prehi = 2'd0; n_bc = '0; n_poll = '0;
                n_phase = PH_CMD_PRE;
            end
            default: begin
                unique case (r_phase)
                    PH_POWERUP: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= {3'd0, i_cfg.powerup}) begin
                            n_retry = '0; n_cidx = CMD0; n_carg = '0; n_prelo = 2'd1;
                            n_prehi = 2'd0; n_bc = '0; n_poll = '0; n_phase = PH_CMD_PRE;
                        end
                    end
                    PH_CMD_PRE: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= ({9'd0, r_prelo} + {9'd0, r_prehi})) begin
                            n_phase = PH_CMD_SEND; n_bc = '0;
                        end
                    end
                    PH_CMD_SEND: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= 11'd6) begin
                            n_phase = PH_CMD_RESP; n_poll = '0;
                        end
                    end
                    PH_CMD_RESP: begin
                        if (i_rx_byte != 8'hFF) s_resp = 1'b1;
                        else begin
                            n_poll = s_poll_inc[19:0];
                            if (s_poll_inc >= {13'd0, i_cfg.resp_wait}) s_resp = 1'b1;
                        end
                    end
                    PH_TAIL: begin
                        n_tail = {r_tail[23:0], i_rx_byte};
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= 11'd4) begin
                            if (r_cidx == CMD8) begin
                                // echo is the last two bytes: voltage nibble then pattern
                                if (r_tail[7:0] == 8'h01 && i_rx_byte == 8'hAA) begin
                                    n_v2 = 1'b1; n_retry = '0; n_cidx = CMD55; n_carg = '0;
                                    n_prelo = 2'd2; n_prehi = 2'd0; n_bc = '0; n_poll = '0;
                                    n_phase = PH_CMD_PRE;
                                end else begin
                                    n_fin = ST_UNKNOWN; n_phase = PH_RELEASE;
                                end
                            end else begin
                                n_found = r_tail[22] ? CT_SDHC : CT_SDV2;
                                n_fin = ST_OK; n_phase = PH_RELEASE;
                            end
                        end
                    end
                    PH_RD_TOKEN: begin
                        if (i_rx_byte == 8'hFE) begin
                            n_phase = PH_RD_DATA; n_bc = '0;
                        end else begin
                            n_poll = s_poll_inc[19:0];
                            if (s_poll_inc >= {5'd0, i_cfg.token_wait}) begin
                                n_fin = ST_TOKEN_TO; n_phase = PH_RELEASE;
                            end
                        end
                    end
                    PH_RD_DATA: begin
                        s_dout = i_rx_byte; s_dval = 1'b1;
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= (BC_W+1)'(BLOCK_BYTES)) begin
                            n_phase = PH_RD_CRC; n_bc = '0;
                        end
                    end
                    PH_RD_CRC: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= 11'd2) begin
                            n_fin = ST_OK; n_phase = PH_RELEASE;
                        end
                    end
                    PH_WR_GAP: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= 11'd3) n_phase = PH_WR_TOKEN;
                    end
                    PH_WR_TOKEN: begin
                        n_phase = PH_WR_DATA; n_bc = '0;
                    end
                    PH_WR_DATA: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= (BC_W+1)'(BLOCK_BYTES)) begin
                            n_phase = PH_WR_CRC; n_bc = '0;
                        end
                    end
                    PH_WR_CRC: begin
                        n_bc = s_bc_inc[BC_W-1:0];
                        if (s_bc_inc >= 11'd2) n_phase = PH_WR_RESP;
                    end
                    PH_WR_RESP: begin
                        if (i_rx_byte[4:0] != 5'h05) begin
                            n_fin = ST_DATA_REJ; n_phase = PH_RELEASE;
                        end else begin
                            n_phase = PH_WR_BUSY; n_poll = '0;
                        end
                    end
                    PH_WR_BUSY: begin
                        if (i_rx_byte != 8'd0) begin
                            n_fin = ST_OK; n_phase = PH_RELEASE;
                        end else if (r_poll >= i_cfg.busy_wait) begin
                            n_fin = ST_BUSY_TO; n_phase = PH_RELEASE;
                        end else n_poll = s_poll_inc[19:0];
                    end
                    PH_RELEASE: begin
                        s_done = 1'b1; s_st = r_fin;
                        if (r_op == OP_INIT && r_fin == ST_OK) n_dtype = r_found;
                        n_phase = PH_IDLE;
                    end
                    default: ;
                endcase

                if (s_resp) begin
                    // poll timeout reports 0xff, which equals rx here anyway
                    s_r = i_rx_byte;
                    // default next command setup; arms override
                    n_carg = '0; n_prelo = 2'd1; n_prehi = 2'd0; n_bc = '0; n_poll = '0;
                    n_phase = PH_CMD_PRE;
                    priority case (r_cidx)
                        CMD0: begin
                            if (s_r == 8'h01) begin
                                n_retry = '0; n_cidx = CMD8; n_carg = 32'h0000_01AA;
                                n_prelo = 2'd0; n_prehi = 2'd3;
                            end else if (r_retry < {4'd0, i_cfg.idle_retry}) begin
                                n_retry = s_retry_inc[11:0]; n_cidx = CMD0;
                            end else begin
                                n_fin = ST_IDLE_FAIL; n_phase = PH_RELEASE;
                            end
                        end
                        CMD8: begin
                            if (s_r == 8'h01) begin
                                n_phase = PH_TAIL; n_tail = '0;
                                n_carg = r_carg;
                            end else if (s_r == 8'h05) begin
                                n_v2 = 1'b0; n_retry = '0; n_cidx = CMD55; n_prelo = 2'd2;
                            end else if (r_retry < {4'd0, i_cfg.idle_retry}) begin
                                n_retry = s_retry_inc[11:0]; n_cidx = CMD8;
                                n_carg = 32'h0000_01AA; n_prelo = 2'd0; n_prehi = 2'd3;
                            end else begin
                                n_fin = ST_UNKNOWN; n_phase = PH_RELEASE;
                            end
                        end
                        CMD55: begin
                            if (r_v2) begin
                                n_cidx = CMD41; n_carg = 32'h4000_0000;
                            end else if (s_r != 8'h01) begin
                                n_fin = ST_SETUP; n_phase = PH_RELEASE;
                            end else n_cidx = CMD41;
                        end
                        CMD41: begin
                            if (r_v2) begin
                                if (s_r == 8'h00) begin
                                    n_retry = '0; n_cidx = CMD58; n_prelo = 2'd0;
                                    n_prehi = 2'd3;
                                end else if (r_retry < i_cfg.acmd_retry) begin
                                    n_retry = s_retry_inc[11:0]; n_cidx = CMD55;
                                end else begin
                                    n_fin = ST_IDLE_FAIL; n_phase = PH_RELEASE;
                                end
                            end else if (s_r == 8'h00) begin
                                n_found = CT_SDV1; n_cidx = CMD59;
                            end else begin
                                n_retry = s_retry_inc[11:0];
                                if (s_retry_inc >= {1'b0, i_cfg.leg_retry}) begin
                                    n_retry = '0; n_cidx = CMD1;
                                end else n_cidx = CMD55;
                            end
                        end
                        CMD1: begin
                            if (s_r == 8'h00) begin
                                n_found = CT_MMC; n_cidx = CMD59;
                            end else begin
                                n_retry = s_retry_inc[11:0];
                                if (s_retry_inc >= {1'b0, i_cfg.leg_retry}) begin
                                    n_fin = ST_IDLE_FAIL; n_phase = PH_RELEASE;
                                end else n_cidx = CMD1;
                            end
                        end
                        CMD59: begin
                            if (s_r == 8'h00) begin
                                n_cidx = CMD16; n_carg = 32'(BLOCK_BYTES);
                            end else begin
                                n_fin = ST_SETUP; n_phase = PH_RELEASE;
                            end
                        end
                        CMD16: begin
                            n_fin = (s_r == 8'h00) ? ST_OK : ST_SETUP;
                            n_phase = PH_RELEASE;
                        end
                        CMD58: begin
                            if (s_r == 8'h00) begin
                                n_phase = PH_TAIL; n_tail = '0; n_carg = r_carg;
                            end else if (r_retry < {4'd0, i_cfg.idle_retry}) begin
                                n_retry = s_retry_inc[11:0]; n_cidx = CMD58;
                                n_prelo = 2'd0; n_prehi = 2'd3;
                            end else begin
                                n_fin = ST_SETUP; n_phase = PH_RELEASE;
                            end
                        end
                        CMD17: begin
                            n_carg = r_carg;
                            if (s_r == 8'h00) begin
                                n_phase = PH_RD_TOKEN;
                            end else begin
                                n_fin = ST_CMD_REJ; n_phase = PH_RELEASE;
                            end
                        end
                        CMD24: begin
                            n_carg = r_carg;
                            if (s_r == 8'h00) begin
                                n_phase = PH_WR_GAP;
                            end else begin
                                n_fin = ST_CMD_REJ; n_phase = PH_RELEASE;
                            end
                        end
                        default: begin
                            n_fin = ST_SETUP; n_phase = PH_RELEASE;
                        end
                    endcase
                    // keep untouched state where the model does not reset it
                    if (n_phase == PH_RELEASE) begin
                        n_carg = r_carg; n_prelo = r_prelo; n_prehi = r_prehi;
                        n_bc = r_bc; n_poll = s_poll_inc[19:0];
                        if (i_rx_byte != 8'hFF) n_poll = r_poll;
                    end
                    if (n_phase == PH_TAIL) begin
                        n_prelo = r_prelo; n_prehi = r_prehi;
                        n_poll = (i_rx_byte != 8'hFF) ? r_poll : s_poll_inc[19:0];
                    end
                    if (n_phase == PH_RD_TOKEN) begin
                        n_prelo = r_prelo; n_prehi = r_prehi; n_bc = r_bc;
                    end
                    if (n_phase == PH_WR_GAP) begin
                        n_prelo = r_prelo; n_prehi = r_prehi;
                        n_poll = (i_rx_byte != 8'hFF) ? r_poll : s_poll_inc[19:0];
                    end
                end
            end
        endcase
    end

    // result for the next exchange
    always_comb begin
        o_res.tx_byte = 8'hFF; o_res.tx_valid = 1'b1; o_res.chip_select = 1'b1;
        o_res.data_out = s_dout; o_res.data_valid = s_dval; o_res.data_taken = 1'b0;
        o_res.done_res = s_done; o_res.status = s_st; o_res.card_type = n_dtype;
        unique case (n_phase)
            PH_IDLE: begin
                o_res.tx_valid = 1'b0; o_res.chip_select = 1'b0;
            end
            PH_POWERUP, PH_RELEASE: o_res.chip_select = 1'b0;
            PH_CMD_PRE: o_res.chip_select = (n_bc >= {8'd0, n_prelo});
            PH_CMD_SEND: begin
                unique case (n_bc)
                    10'd0: o_res.tx_byte = {2'b01, n_cidx};
                    10'd1: o_res.tx_byte = n_carg[31:24];
                    10'd2: o_res.tx_byte = n_carg[23:16];
                    10'd3: o_res.tx_byte = n_carg[15:8];
                    10'd4: o_res.tx_byte = n_carg[7:0];
                    default: o_res.tx_byte = (n_cidx == CMD0) ? 8'h95 :
                                             (n_cidx == CMD8) ? 8'h87 : 8'h01;
                endcase
            end
            PH_WR_TOKEN: o_res.tx_byte = 8'hFE;
            PH_WR_DATA: begin
                o_res.tx_byte = i_wr_data; o_res.data_taken = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_dtype <= CT_NONE; r_bc <= '0; r_poll <= '0;
            r_retry <= '0; r_cidx <= '0; r_carg <= '0; r_op <= OP_INIT;
            r_found <= CT_NONE; r_prelo <= '0; r_prehi <= '0; r_tail <= '0;
            r_fin <= ST_OK; r_v2 <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase; r_dtype <= n_dtype; r_bc <= n_bc; r_poll <= n_poll;
            r_retry <= n_retry; r_cidx <= n_cidx; r_carg <= n_carg; r_op <= n_op;
            r_found <= n_found; r_prelo <= n_prelo; r_prehi <= n_prehi;
            r_tail <= n_tail; r_fin <= n_fin; r_v2 <= n_v2;
        end
    end
endmodule
`default_nettype wire

@@ hdl/sd_spi_host_sequencer.sv @@
// top level: input register, sequencer core, result register
// a request is registered in the input register, then its result in the result register
// throughput: one request per cycle unless output stalls; core advances once per request
// a full result register stalls the input only when the result is not taken
// reset (synchronous, active low) clears the sequencer to idle, no card, and
// loads the default limits; no clearing pass
`default_nettype none
module sd_spi_host_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_sector,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [7:0]  i_wr_data,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [7:0]  o_tx_byte,
    output      logic        o_tx_valid,
    output      logic        o_chip_select,
    output      logic [7:0]  o_data_out,
    output      logic        o_data_valid,
    output      logic        o_data_taken,
    output      logic        o_done_res,
    output      logic [2:0]  o_status,
    output      logic [2:0]  o_card_type
);
    import sdspi_pkg::*;

    t_cfg        s_cfg;
    t_result     s_res;
    logic        r_in_v;
    logic [1:0]  r_mode;
    logic [31:0] r_sector;
    logic [7:0]  r_rx, r_wr;
    logic        r_out_v;
    t_result     r_out;
    logic        s_step;

    sdspi_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .o_cfg(s_cfg)
    );

    // core fires when the result register is free or being drained
    assign s_step  = r_in_v && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || s_step;

    sdspi_core u_core (
        .i_clk, .i_rst_n, .i_step(s_step), .i_cfg(s_cfg), .i_mode(r_mode),
        .i_sector(r_sector), .i_rx_byte(r_rx), .i_wr_data(r_wr), .o_res(s_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0; r_out_v <= 1'b0;
        end else begin
            if (o_ready) r_in_v <= i_valid;
            if (s_step) r_out_v <= 1'b1;
            else if (i_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mode <= i_mode; r_sector <= i_sector; r_rx <= i_rx_byte; r_wr <= i_wr_data;
        end
        if (s_step) r_out <= s_res;
    end

    assign o_valid       = r_out_v;
    assign o_tx_byte     = r_out.tx_byte;
    assign o_tx_valid    = r_out.tx_valid;
    assign o_chip_select = r_out.chip_select;
    assign o_data_out    = r_out.data_out;
    assign o_data_valid  = r_out.data_valid;
    assign o_data_taken  = r_out.data_taken;
    assign o_done_res    = r_out.done_res;
    assign o_status      = r_out.status;
    assign o_card_type   = r_out.card_type;
endmodule
`default_nettype wire
